FILE: rtl/tva_pkg.sv
// shared types, codes and constants of the timed valve actuator
package tva_pkg;

    // command codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_OPEN  = 3'd1,
        MODE_CLOSE = 3'd2,
        MODE_GOTO  = 3'd3,
        MODE_SHIFT = 3'd4
    } mode_t;

    // configuration register indexes
    typedef enum logic {
        CFG_FULL_STROKE    = 1'b0,
        CFG_MS_PER_PERCENT = 1'b1
    } cfg_idx_t;

    localparam int          STROKE_W      = 18;
    localparam int          RATE_W        = 12;
    localparam int          PCT_W         = 7;
    localparam int          ELAPSED_W     = 19;
    localparam int          CFG_DATA_W    = STROKE_W;

    localparam logic [PCT_W-1:0]     FULL_PERCENT  = 7'd100;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [STROKE_W-1:0]  STROKE_RESET  = 18'd60000;
    localparam logic [RATE_W-1:0]    RATE_RESET    = 12'd600;

    // one input item
    typedef struct packed {
        logic [2:0]        mode;
        logic signed [7:0] amount;
    } in_t;

    // one result item
    typedef struct packed {
        logic             open_drive;
        logic             close_drive;
        logic [PCT_W-1:0] position;
        logic             stroke_busy;
        logic             pulse_busy;
    } out_t;

    // configuration registers seen by the core
    typedef struct packed {
        logic [STROKE_W-1:0] full_stroke_ms;
        logic [RATE_W-1:0]   ms_per_percent;
    } cfg_t;

endpackage

FILE: rtl/tva_core.sv
// valve state registers and the single-pass command update
module tva_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  tva_pkg::in_t  item,
    input  tva_pkg::cfg_t cfg,
    output tva_pkg::out_t res
);
    import tva_pkg::*;

    logic                 stroke_active_reg, stroke_active_next;
    logic                 pulse_active_reg, pulse_active_next;
    logic [PCT_W-1:0]     pulse_percent_reg, pulse_percent_next;
    logic [PCT_W-1:0]     position_reg, position_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 open_reg, open_next;
    logic                 close_reg, close_next;

    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [ELAPSED_W-1:0] pulse_ms;
    logic signed [8:0]    shift_sum;
    logic [PCT_W-1:0]     shift_pos;
    logic signed [7:0]    shift_delta;
    logic [PCT_W-1:0]     shift_mag;
    logic [PCT_W-1:0]     goto_target;

    // saturating ms count and pulse length
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : elapsed_reg + 1'b1;
    assign pulse_ms    = ELAPSED_W'(pulse_percent_reg) * ELAPSED_W'(cfg.ms_per_percent);

    // shift target clamped to the travel range
    assign shift_sum   = $signed({2'b00, position_reg}) + $signed({item.amount[7], item.amount});
    always_comb
    begin
        if (shift_sum < 9'sd0)
            shift_pos = '0;
        else if (shift_sum > $signed({2'b00, FULL_PERCENT}))
            shift_pos = FULL_PERCENT;
        else
            shift_pos = shift_sum[PCT_W-1:0];
    end
    assign shift_delta = $signed({1'b0, shift_pos}) - $signed({1'b0, position_reg});
    assign shift_mag   = shift_delta[7] ? PCT_W'(-shift_delta) : shift_delta[PCT_W-1:0];

    // go-to target clamped to the travel range
    always_comb
    begin
        if (item.amount < 8'sd0)
            goto_target = '0;
        else if (item.amount > $signed({1'b0, FULL_PERCENT}))
            goto_target = FULL_PERCENT;
        else
            goto_target = item.amount[PCT_W-1:0];
    end

    // command update
    always_comb
    begin
        stroke_active_next = stroke_active_reg;
        pulse_active_next  = pulse_active_reg;
        pulse_percent_next = pulse_percent_reg;
        position_next      = position_reg;
        elapsed_next       = elapsed_reg;
        open_next          = open_reg;
        close_next         = close_reg;
        unique case (mode_t'(item.mode))
            MODE_TICK:
            begin
                elapsed_next = elapsed_inc;
                if (stroke_active_reg)
                begin
                    if (elapsed_inc > ELAPSED_W'(cfg.full_stroke_ms))
                    begin
                        stroke_active_next = 1'b0;
                        close_next         = 1'b0;
                        if (pulse_percent_reg != '0)
                        begin
                            position_next = pulse_percent_reg;
                            open_next     = 1'b1;
                            elapsed_next  = '0;
                        end
                        else
                        begin
                            position_next = open_reg ? FULL_PERCENT : '0;
                            open_next     = 1'b0;
                        end
                    end
                end
                else if (pulse_active_reg && (elapsed_inc > pulse_ms))
                begin
                    open_next          = 1'b0;
                    close_next         = 1'b0;
                    pulse_active_next  = 1'b0;
                    pulse_percent_next = '0;
                end
            end
            MODE_OPEN:
            begin
                if (!stroke_active_reg)
                begin
                    stroke_active_next = 1'b1;
                    elapsed_next       = '0;
                    open_next          = 1'b1;
                end
            end
            MODE_CLOSE:
            begin
                if (!stroke_active_reg)
                begin
                    stroke_active_next = 1'b1;
                    elapsed_next       = '0;
                    close_next         = 1'b1;
                end
            end
            MODE_GOTO:
            begin
                pulse_active_next  = 1'b1;
                stroke_active_next = 1'b1;
                elapsed_next       = '0;
                close_next         = 1'b1;
                pulse_percent_next = goto_target;
                position_next      = goto_target;
            end
            MODE_SHIFT:
            begin
                if (shift_delta != 8'sd0)
                begin
                    pulse_active_next  = 1'b1;
                    elapsed_next       = '0;
                    position_next      = shift_pos;
                    pulse_percent_next = shift_mag;
                    if (shift_delta[7])
                        close_next = 1'b1;
                    else
                        open_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result seen after the update
    assign res = '{open_drive:  open_next,
                   close_drive: close_next,
                   position:    position_next,
                   stroke_busy: stroke_active_next,
                   pulse_busy:  pulse_active_next};

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stroke_active_reg <= 1'b0;
            pulse_active_reg  <= 1'b0;
            pulse_percent_reg <= '0;
            position_reg      <= '0;
            elapsed_reg       <= '0;
            open_reg          <= 1'b0;
            close_reg         <= 1'b0;
        end
        else if (advance)
        begin
            stroke_active_reg <= stroke_active_next;
            pulse_active_reg  <= pulse_active_next;
            pulse_percent_reg <= pulse_percent_next;
            position_reg      <= position_next;
            elapsed_reg       <= elapsed_next;
            open_reg          <= open_next;
            close_reg         <= close_next;
        end
    end

`ifndef SYNTHESIS
    // position estimate stays within the travel range
    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= FULL_PERCENT)
        else $error("position estimate out of range");

    // a pending pulse length implies the pulse is marked active
    a_pulse_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_percent_reg != '0) |-> pulse_active_reg)
        else $error("pulse length set without active pulse");

    // state holds when no item is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(elapsed_reg) && $stable(position_reg))
        else $error("state changed without an item");
`endif

endmodule

FILE: rtl/timed_valve_actuator_unit.sv
// top level of the timed valve actuator: handshake, config registers, result register
//
//  port group   direction  handshake          payload
//  in_*         input      in_valid/in_stall  tva_pkg::in_t (mode, amount)
//  out_*        output     out_valid/out_stall tva_pkg::out_t (drives, position, busy)
//  cfg_*        input      cfg_we             cfg_index, cfg_data
//
// one item per cycle while the result is not stalled; an input transfer goes to the
// input register, then through the single-pass update into the result register
// the update path holds one 7x12 multiply and two 19-bit compares
// rst_n clears state and config to reset values asynchronously
// a stalled result holds the update; the input register takes one more item behind it
module timed_valve_actuator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tva_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tva_pkg::out_t                     out_data,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [tva_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tva_pkg::*;

    logic  in_valid_reg, in_valid_next;
    in_t   item_reg;
    logic  out_valid_reg, out_valid_next;
    out_t  out_data_reg;
    cfg_t  cfg_reg;
    out_t  res;
    logic  advance;
    logic  in_take;

    // pipeline control
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_data;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_stroke_ms <= STROKE_RESET;
            cfg_reg.ms_per_percent <= RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FULL_STROKE:    cfg_reg.full_stroke_ms <= cfg_data;
                CFG_MS_PER_PERCENT: cfg_reg.ms_per_percent <= cfg_data[RATE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // state and update
    tva_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // a processed item always shows up as a result next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid && (out_data == $past(res)))
        else $error("processed item did not reach the result register");

    // a held input item is kept until processed
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(item_reg))
        else $error("held input item lost");

    // reported position within the travel range
    a_out_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.position <= FULL_PERCENT))
        else $error("result position out of range");
`endif

endmodule

FILE: sim/testbench.sv
// self-checking testbench of the timed valve actuator unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tva_pkg::*;

    // mode codes the block leaves unused
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam int         DUT_LATENCY      = 2;
    localparam int         DRAIN_LIMIT      = 20000;
    localparam int         MAX_REPORTS      = 10;
    localparam int         MAX_BURST        = 120;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    in_t                     in_data;
    logic                    out_valid;
    logic                    out_stall;
    out_t                    out_data;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // valve model state and register copies
    logic                    vm_stroke;
    logic                    vm_pulse;
    logic [PCT_W-1:0]        vm_pulse_pct;
    logic [PCT_W-1:0]        vm_position;
    logic [ELAPSED_W-1:0]    vm_elapsed;
    logic                    vm_open;
    logic                    vm_close;
    logic [STROKE_W-1:0]     vm_stroke_ms;
    logic [RATE_W-1:0]       vm_rate;

    out_t                    pending_status[$];
    int                      send_idle_pct;
    int                      recv_stall_pct;
    int                      n_errors;
    int                      n_commands;
    int                      n_status_checked;
    int                      n_reg_writes;

    timed_valve_actuator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // one millisecond tick of the valve model
    function automatic void valve_tick();
        int pulse_limit;
        if (vm_elapsed != ELAPSED_MAX)
            vm_elapsed = vm_elapsed + 1'b1;
        pulse_limit = 32'(vm_pulse_pct) * 32'(vm_rate);
        if (vm_stroke) begin
            if (vm_elapsed > vm_stroke_ms) begin
                vm_position = vm_open ? FULL_PERCENT : '0;
                vm_open     = 1'b0;
                vm_close    = 1'b0;
                vm_stroke   = 1'b0;
                if (vm_pulse_pct != '0) begin
                    vm_position = vm_pulse_pct;
                    vm_open     = 1'b1;
                    vm_elapsed  = '0;
                end
            end
        end
        else if (vm_pulse) begin
            if (32'(vm_elapsed) > pulse_limit) begin
                vm_open      = 1'b0;
                vm_close     = 1'b0;
                vm_pulse     = 1'b0;
                vm_pulse_pct = '0;
            end
        end
    endfunction

    // relative move, clamped to the valve travel
    function automatic void valve_shift(int shift);
        int pos;
        pos = int'(vm_position);
        if (pos + shift > int'(FULL_PERCENT))
            shift = int'(FULL_PERCENT) - pos;
        if (pos + shift < 0)
            shift = -pos;
        if (shift != 0) begin
            vm_pulse    = 1'b1;
            vm_elapsed  = '0;
            vm_position = PCT_W'(pos + shift);
            if (shift < 0) begin
                vm_pulse_pct = PCT_W'(-shift);
                vm_close     = 1'b1;
            end
            else begin
                vm_pulse_pct = PCT_W'(shift);
                vm_open      = 1'b1;
            end
        end
    endfunction

    // advance the valve model by one command and return the status it shows
    function automatic out_t valve_advance(in_t cmd);
        int   amt;
        int   target;
        out_t status;
        amt = $signed(cmd.amount);
        case (cmd.mode)
            MODE_TICK:
                valve_tick();
            MODE_OPEN:
                if (!vm_stroke) begin
                    vm_stroke  = 1'b1;
                    vm_elapsed = '0;
                    vm_open    = 1'b1;
                end
            MODE_CLOSE:
                if (!vm_stroke) begin
                    vm_stroke  = 1'b1;
                    vm_elapsed = '0;
                    vm_close   = 1'b1;
                end
            MODE_GOTO: begin
                target = amt;
                if (target < 0)
                    target = 0;
                if (target > int'(FULL_PERCENT))
                    target = int'(FULL_PERCENT);
                vm_pulse     = 1'b1;
                vm_stroke    = 1'b1;
                vm_elapsed   = '0;
                vm_close     = 1'b1;
                vm_pulse_pct = PCT_W'(target);
                vm_position  = PCT_W'(target);
            end
            MODE_SHIFT:
                valve_shift(amt);
            default: ;
        endcase
        status.open_drive  = vm_open;
        status.close_drive = vm_close;
        status.position    = vm_position;
        status.stroke_busy = vm_stroke;
        status.pulse_busy  = vm_pulse;
        return status;
    endfunction

    function automatic in_t make_cmd(logic [2:0] mode, int amount);
        in_t cmd;
        cmd.mode   = mode;
        cmd.amount = amount[7:0];
        return cmd;
    endfunction

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // one command transfer, with random idle cycles ahead of it
    task automatic send_cmd(in_t cmd);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        do
            @(posedge clk);
        while (in_stall);
        pending_status.push_back(valve_advance(cmd));
        n_commands++;
    endtask

    // stop sending and let every expected status come out
    task automatic wait_drained();
        int guard;
        @(negedge clk);
        in_valid <= 1'b0;
        guard = 0;
        while (pending_status.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (DUT_LATENCY + 2) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_FULL_STROKE:    vm_stroke_ms = value;
            CFG_MS_PER_PERCENT: vm_rate      = value[RATE_W-1:0];
            default: ;
        endcase
        n_reg_writes++;
    endtask

    function automatic in_t random_cmd();
        int         pick;
        int         amount;
        logic [2:0] mode;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            mode = MODE_OPEN;
        else if (pick < 40)
            mode = MODE_CLOSE;
        else if (pick < 62)
            mode = MODE_GOTO;
        else if (pick < 92)
            mode = MODE_SHIFT;
        else
            mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        if ($urandom_range(0, 3) == 0)
            amount = $urandom_range(0, 255);
        else
            amount = int'($urandom_range(0, 200)) - 100;
        return make_cmd(mode, amount);
    endfunction

    // config writes, then random commands, each followed by a run of ticks of random length, optionally drained halfway
    task automatic run_segment(int stroke_ms, int rate, int n_items, bit pause_midway);
        int sent;
        int burst;
        int burst_max;
        bit paused;
        write_reg(CFG_FULL_STROKE, CFG_DATA_W'(stroke_ms));
        write_reg(CFG_MS_PER_PERCENT, {6'($urandom_range(0, 63)), RATE_W'(rate)});
        burst_max = stroke_ms + 100 * rate + 2;
        if (burst_max > MAX_BURST)
            burst_max = MAX_BURST;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            send_cmd(random_cmd());
            sent++;
            if ($urandom_range(0, 3) == 0)
                burst = $urandom_range(0, 4);
            else
                burst = $urandom_range(0, burst_max);
            for (int i = 0; i < burst && sent < n_items; i++) begin
                send_cmd(make_cmd(MODE_TICK, $urandom_range(0, 255)));
                sent++;
            end
            if (pause_midway && !paused && sent >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    // command set and clamping with the reset timing
    task automatic test_commands_at_reset_timing();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_cmd(make_cmd(MODE_TICK, 0));
        send_cmd(make_cmd(MODE_SPARE_FIRST, -1));
        send_cmd(make_cmd(MODE_SPARE_LAST, 127));
        send_cmd(make_cmd(MODE_SHIFT, 0));
        send_cmd(make_cmd(MODE_SHIFT, -5));
        send_cmd(make_cmd(MODE_SHIFT, 127));
        send_cmd(make_cmd(MODE_SHIFT, -128));
        send_cmd(make_cmd(MODE_TICK, -128));
        send_cmd(make_cmd(MODE_OPEN, 0));
        send_cmd(make_cmd(MODE_CLOSE, 0));
        send_cmd(make_cmd(MODE_SHIFT, 30));
        send_cmd(make_cmd(MODE_GOTO, -128));
        send_cmd(make_cmd(MODE_GOTO, 127));
        send_cmd(make_cmd(MODE_GOTO, 100));
    endtask

    // stroke and pulse ends with zero and short timing
    task automatic test_stroke_and_pulse_ends();
        write_reg(CFG_FULL_STROKE, '0);
        write_reg(CFG_MS_PER_PERCENT, '0);
        send_cmd(make_cmd(MODE_GOTO, 50));
        send_cmd(make_cmd(MODE_TICK, 0));
        send_cmd(make_cmd(MODE_TICK, 0));
        send_cmd(make_cmd(MODE_GOTO, 0));
        send_cmd(make_cmd(MODE_TICK, 0));
        send_cmd(make_cmd(MODE_OPEN, 0));
        send_cmd(make_cmd(MODE_TICK, 0));
        send_cmd(make_cmd(MODE_CLOSE, 0));
        send_cmd(make_cmd(MODE_TICK, 0));
        write_reg(CFG_FULL_STROKE, CFG_DATA_W'(2));
        write_reg(CFG_MS_PER_PERCENT, CFG_DATA_W'(1));
        send_cmd(make_cmd(MODE_GOTO, 3));
        repeat (7) send_cmd(make_cmd(MODE_TICK, 0));
    endtask

    task automatic test_random_slow_receiver();
        send_idle_pct  = 9;
        recv_stall_pct = 69;
        run_segment($urandom_range(0, 24), $urandom_range(0, 2), 120, 1'b0);
        run_segment(0, 0, 120, 1'b0);
        run_segment($urandom_range(0, 24), $urandom_range(0, 2), 120, 1'b0);
    endtask

    task automatic test_random_slow_sender();
        send_idle_pct  = 69;
        recv_stall_pct = 9;
        run_segment($urandom_range(0, 24), $urandom_range(0, 2), 120, 1'b0);
        run_segment((1 << STROKE_W) - 1, (1 << RATE_W) - 1, 120, 1'b0);
        run_segment($urandom_range(0, 24), $urandom_range(0, 2), 120, 1'b0);
    endtask

    task automatic test_random_full_rate();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_segment($urandom_range(0, 24), $urandom_range(0, 2), 120, 1'b1);
        run_segment($urandom_range(0, 24), $urandom_range(0, 2), 120, 1'b0);
        run_segment($urandom_range(0, 24), $urandom_range(0, 2), 120, 1'b1);
    endtask

    // receiver stall, changed at the falling edge
    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // compare each status transfer with the oldest expectation
    always @(posedge clk) begin
        out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_status.size() == 0) begin
                report_mismatch($sformatf("unexpected status %h", out_data));
            end
            else begin
                want = pending_status.pop_front();
                if (out_data.open_drive !== want.open_drive)
                    report_mismatch($sformatf("status %0d open_drive: expected %b, got %b",
                        n_status_checked, want.open_drive, out_data.open_drive));
                if (out_data.close_drive !== want.close_drive)
                    report_mismatch($sformatf("status %0d close_drive: expected %b, got %b",
                        n_status_checked, want.close_drive, out_data.close_drive));
                if (out_data.position !== want.position)
                    report_mismatch($sformatf("status %0d position: expected %0d, got %0d",
                        n_status_checked, want.position, out_data.position));
                if (out_data.stroke_busy !== want.stroke_busy)
                    report_mismatch($sformatf("status %0d stroke_busy: expected %b, got %b",
                        n_status_checked, want.stroke_busy, out_data.stroke_busy));
                if (out_data.pulse_busy !== want.pulse_busy)
                    report_mismatch($sformatf("status %0d pulse_busy: expected %b, got %b",
                        n_status_checked, want.pulse_busy, out_data.pulse_busy));
                n_status_checked++;
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // reset, tests in turn, final verdict
    initial begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_data          = '0;
        out_stall        = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_FULL_STROKE;
        cfg_data         = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        n_errors         = 0;
        n_commands       = 0;
        n_status_checked = 0;
        n_reg_writes     = 0;
        vm_stroke        = 1'b0;
        vm_pulse         = 1'b0;
        vm_pulse_pct     = '0;
        vm_position      = '0;
        vm_elapsed       = '0;
        vm_open          = 1'b0;
        vm_close         = 1'b0;
        vm_stroke_ms     = STROKE_RESET;
        vm_rate          = RATE_RESET;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_commands_at_reset_timing();
        test_stroke_and_pulse_ends();
        test_random_slow_receiver();
        test_random_slow_sender();
        test_random_full_rate();

        wait_drained();
        repeat (DUT_LATENCY + 4) @(posedge clk);
        if (pending_status.size() != 0)
            report_mismatch($sformatf("%0d expected status transfers never came",
                pending_status.size()));
        $display("sent %0d valve commands, checked %0d status transfers", n_commands,
            n_status_checked);
        $display("%0d register writes, %0d mismatches", n_reg_writes, n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
